FILE: design/tnrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnrd_pkg
// Widths, arithmetic constants and the reciprocal seed table of the divider.
// ----------------------------------------------------------------------------
package tnrd_pkg;

	localparam int DEPTH_W = 16;
	localparam int QUOT_W  = 17;
	localparam int NUM_W   = 31;
	localparam int RECIP_W = 10;
	localparam int EST1_W  = 18;
	localparam int EST2_W  = 19;
	localparam int PROD_W  = EST2_W + NUM_W;
	localparam int LZC_W   = 4;
	localparam int IDX_W   = 9;

	localparam logic [QUOT_W-1:0]  QUOT_MAX    = 17'h1ffff;
	localparam logic [25:0]        NR_TWO      = 26'h2000080;
	localparam logic [28:0]        NR_ROUND    = 29'h0000080;
	localparam logic [PROD_W:0]    Q_ROUND     = 51'h0008000;
	localparam logic [14:0]        MANT_MASK   = 15'h7fff;
	localparam logic [15:0]        IDX_ROUND   = 16'h0040;
	localparam logic [RECIP_W-1:0] SEED_OFFSET = 10'h101;

	localparam logic [7:0] SEED_ROM [0:256] = '{
		8'hff, 8'hfd, 8'hfb, 8'hf9, 8'hf7, 8'hf5, 8'hf3, 8'hf1,
		8'hef, 8'hee, 8'hec, 8'hea, 8'he8, 8'he6, 8'he4, 8'he3,
		8'he1, 8'hdf, 8'hdd, 8'hdc, 8'hda, 8'hd8, 8'hd6, 8'hd5,
		8'hd3, 8'hd1, 8'hd0, 8'hce, 8'hcd, 8'hcb, 8'hc9, 8'hc8,
		8'hc6, 8'hc5, 8'hc3, 8'hc1, 8'hc0, 8'hbe, 8'hbd, 8'hbb,
		8'hba, 8'hb8, 8'hb7, 8'hb5, 8'hb4, 8'hb2, 8'hb1, 8'hb0,
		8'hae, 8'had, 8'hab, 8'haa, 8'ha9, 8'ha7, 8'ha6, 8'ha4,
		8'ha3, 8'ha2, 8'ha0, 8'h9f, 8'h9e, 8'h9c, 8'h9b, 8'h9a,
		8'h99, 8'h97, 8'h96, 8'h95, 8'h94, 8'h92, 8'h91, 8'h90,
		8'h8f, 8'h8d, 8'h8c, 8'h8b, 8'h8a, 8'h89, 8'h87, 8'h86,
		8'h85, 8'h84, 8'h83, 8'h82, 8'h81, 8'h7f, 8'h7e, 8'h7d,
		8'h7c, 8'h7b, 8'h7a, 8'h79, 8'h78, 8'h77, 8'h75, 8'h74,
		8'h73, 8'h72, 8'h71, 8'h70, 8'h6f, 8'h6e, 8'h6d, 8'h6c,
		8'h6b, 8'h6a, 8'h69, 8'h68, 8'h67, 8'h66, 8'h65, 8'h64,
		8'h63, 8'h62, 8'h61, 8'h60, 8'h5f, 8'h5e, 8'h5d, 8'h5d,
		8'h5c, 8'h5b, 8'h5a, 8'h59, 8'h58, 8'h57, 8'h56, 8'h55,
		8'h54, 8'h53, 8'h53, 8'h52, 8'h51, 8'h50, 8'h4f, 8'h4e,
		8'h4d, 8'h4d, 8'h4c, 8'h4b, 8'h4a, 8'h49, 8'h48, 8'h48,
		8'h47, 8'h46, 8'h45, 8'h44, 8'h43, 8'h43, 8'h42, 8'h41,
		8'h40, 8'h3f, 8'h3f, 8'h3e, 8'h3d, 8'h3c, 8'h3c, 8'h3b,
		8'h3a, 8'h39, 8'h39, 8'h38, 8'h37, 8'h36, 8'h36, 8'h35,
		8'h34, 8'h33, 8'h33, 8'h32, 8'h31, 8'h31, 8'h30, 8'h2f,
		8'h2e, 8'h2e, 8'h2d, 8'h2c, 8'h2c, 8'h2b, 8'h2a, 8'h2a,
		8'h29, 8'h28, 8'h28, 8'h27, 8'h26, 8'h26, 8'h25, 8'h24,
		8'h24, 8'h23, 8'h22, 8'h22, 8'h21, 8'h20, 8'h20, 8'h1f,
		8'h1e, 8'h1e, 8'h1d, 8'h1d, 8'h1c, 8'h1b, 8'h1b, 8'h1a,
		8'h19, 8'h19, 8'h18, 8'h18, 8'h17, 8'h16, 8'h16, 8'h15,
		8'h15, 8'h14, 8'h14, 8'h13, 8'h12, 8'h12, 8'h11, 8'h11,
		8'h10, 8'h0f, 8'h0f, 8'h0e, 8'h0e, 8'h0d, 8'h0d, 8'h0c,
		8'h0c, 8'h0b, 8'h0a, 8'h0a, 8'h09, 8'h09, 8'h08, 8'h08,
		8'h07, 8'h07, 8'h06, 8'h06, 8'h05, 8'h05, 8'h04, 8'h04,
		8'h03, 8'h03, 8'h02, 8'h02, 8'h01, 8'h01, 8'h00, 8'h00,
		8'h00
	};

endpackage

FILE: design/table_newton_reciprocal_divider_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_newton_reciprocal_divider_top
// Pipelined unsigned divider: proj_distance * 65536 / depth, clamped to 17 bits.
// ----------------------------------------------------------------------------
// Usage:
//   The cfg channel writes proj_distance (the dividend); write it while the
//   pipeline is empty. cfg_ready is always high.
//   Each word on the slave stream carries one depth (the divisor). The master
//   stream returns one word per input: the quotient in tdata and the overflow
//   flag in tuser, in input order.
//   An accepted word passes through six register stages (normalize, seed
//   table, two refinement multiplies, the quotient multiply, and round/clamp),
//   each holding one word, before its result is valid on the master side.
//   One word is taken every cycle while s_tready is high.
//   Each stage has its own valid bit and advances whenever the next one is
//   empty or moving, so a stalled receiver only fills the pipeline up; words
//   already inside are held, never dropped or repeated. s_tready falls once
//   all six stages are occupied and m_tready is low.
//   Reset clears every valid bit and sets proj_distance to zero.
// ----------------------------------------------------------------------------
module table_newton_reciprocal_divider_top
	import tnrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,     // proj_distance[15:0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,      // depth[15:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,      // quotient[16:0], zero fill [23:17]
	output logic        m_tuser       // div_overflow
);

	logic [DEPTH_W-1:0] dist_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	logic               ovf_s1, ovf_s2, ovf_s3, ovf_s4, ovf_s5, ovf_s6;
	logic [DEPTH_W-1:0] den_s1, den_s2;
	logic [NUM_W-1:0]   num_s1, num_s2, num_s3, num_s4;
	logic [RECIP_W-1:0] recip_s2, recip_s3;
	logic [EST1_W-1:0]  est1_s3;
	logic [EST2_W-1:0]  est2_s4;
	logic [PROD_W-1:0]  prod_s5;
	logic [QUOT_W-1:0]  quot_s6;

	// Stage 1 combinational signals.
	logic [LZC_W-1:0]   lzc;
	logic               ovf_c;
	// Stage 2.
	logic [15:0]        idx_sum;
	logic [IDX_W-1:0]   idx;
	// Stage 3 to 6.
	logic [25:0]        p1;
	logic [25:0]        diff1;
	logic [27:0]        p2;
	logic [28:0]        sum2;
	logic [PROD_W:0]    sum3;
	logic [PROD_W-16:0] q_wide;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
		end else if (cfg_valid) begin
			dist_q <= cfg_data;
		end
	end

	// A stage may load when it is empty or its word moves on this cycle.
	assign rdy_s6   = !vld_s6 || m_tready;
	assign rdy_s5   = !vld_s5 || rdy_s6;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= s_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	// Stage 1: overflow test, leading zero count, normalization.
	always_comb begin
		lzc = LZC_W'(15);
		for (int i = 0; i < DEPTH_W; i++) begin
			if (s_tdata[i]) lzc = LZC_W'(DEPTH_W - 1 - i);
		end
		ovf_c = ({1'b0, s_tdata, 1'b0} <= {2'b00, dist_q});
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ovf_s1 <= ovf_c;
			den_s1 <= s_tdata << lzc;
			num_s1 <= NUM_W'(dist_q) << lzc;
		end
	end

	// Stage 2: seed lookup from the rounded mantissa.
	always_comb begin
		idx_sum = {1'b0, den_s1[14:0] & MANT_MASK} + IDX_ROUND;
		idx     = idx_sum[15:7];
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			ovf_s2   <= ovf_s1;
			den_s2   <= den_s1;
			num_s2   <= num_s1;
			recip_s2 <= RECIP_W'(SEED_ROM[idx]) + SEED_OFFSET;
		end
	end

	// Stage 3: first refinement, 2 - den * r. The product stays below the
	// constant for any normalized divisor.
	always_comb begin
		p1    = 26'(den_s2) * 26'(recip_s2);
		diff1 = NR_TWO - p1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			ovf_s3   <= ovf_s2;
			num_s3   <= num_s2;
			recip_s3 <= recip_s2;
			est1_s3  <= diff1[25:8];
		end
	end

	// Stage 4: second refinement, rounded scaling by the seed.
	always_comb begin
		p2   = 28'(est1_s3) * 28'(recip_s3);
		sum2 = {1'b0, p2} + NR_ROUND;
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			ovf_s4  <= ovf_s3;
			num_s4  <= num_s3;
			est2_s4 <= sum2[26:8];
		end
	end

	// Stage 5: reciprocal times shifted dividend.
	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			ovf_s5  <= ovf_s4;
			prod_s5 <= PROD_W'(est2_s4) * PROD_W'(num_s4);
		end
	end

	// Stage 6: round, clamp, and force the saturated value on overflow.
	always_comb begin
		sum3   = {1'b0, prod_s5} + Q_ROUND;
		q_wide = sum3[PROD_W:16];
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			ovf_s6 <= ovf_s5;
			if (ovf_s5 || (q_wide > (PROD_W-15)'(QUOT_MAX))) begin
				quot_s6 <= QUOT_MAX;
			end else begin
				quot_s6 <= q_wide[QUOT_W-1:0];
			end
		end
	end

	assign m_tvalid = vld_s6;
	assign m_tdata  = {7'b0, quot_s6};
	assign m_tuser  = ovf_s6;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the table-seeded Newton-Raphson reciprocal divider.
// Depth words go in on the slave stream. Each quotient and overflow flag that
// comes out is checked against a local bit-exact model of the divide. The
// dividend register is changed only while the pipeline is empty. Both streams
// get random idle and stall cycles.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [16:0] QUOTIENT_CLAMP = 17'h1ffff;
	localparam logic [15:0] DIST_MAX       = 16'hffff;
	localparam int          MAX_REPORTS    = 10;
	localparam int          WORDS_PER_CFG  = 48;

	// Reciprocal seeds, indexed by the rounded mantissa of the normalized depth.
	localparam bit [0:256][7:0] RECIP_SEED = {
		8'hff, 8'hfd, 8'hfb, 8'hf9, 8'hf7, 8'hf5, 8'hf3, 8'hf1,
		8'hef, 8'hee, 8'hec, 8'hea, 8'he8, 8'he6, 8'he4, 8'he3,
		8'he1, 8'hdf, 8'hdd, 8'hdc, 8'hda, 8'hd8, 8'hd6, 8'hd5,
		8'hd3, 8'hd1, 8'hd0, 8'hce, 8'hcd, 8'hcb, 8'hc9, 8'hc8,
		8'hc6, 8'hc5, 8'hc3, 8'hc1, 8'hc0, 8'hbe, 8'hbd, 8'hbb,
		8'hba, 8'hb8, 8'hb7, 8'hb5, 8'hb4, 8'hb2, 8'hb1, 8'hb0,
		8'hae, 8'had, 8'hab, 8'haa, 8'ha9, 8'ha7, 8'ha6, 8'ha4,
		8'ha3, 8'ha2, 8'ha0, 8'h9f, 8'h9e, 8'h9c, 8'h9b, 8'h9a,
		8'h99, 8'h97, 8'h96, 8'h95, 8'h94, 8'h92, 8'h91, 8'h90,
		8'h8f, 8'h8d, 8'h8c, 8'h8b, 8'h8a, 8'h89, 8'h87, 8'h86,
		8'h85, 8'h84, 8'h83, 8'h82, 8'h81, 8'h7f, 8'h7e, 8'h7d,
		8'h7c, 8'h7b, 8'h7a, 8'h79, 8'h78, 8'h77, 8'h75, 8'h74,
		8'h73, 8'h72, 8'h71, 8'h70, 8'h6f, 8'h6e, 8'h6d, 8'h6c,
		8'h6b, 8'h6a, 8'h69, 8'h68, 8'h67, 8'h66, 8'h65, 8'h64,
		8'h63, 8'h62, 8'h61, 8'h60, 8'h5f, 8'h5e, 8'h5d, 8'h5d,
		8'h5c, 8'h5b, 8'h5a, 8'h59, 8'h58, 8'h57, 8'h56, 8'h55,
		8'h54, 8'h53, 8'h53, 8'h52, 8'h51, 8'h50, 8'h4f, 8'h4e,
		8'h4d, 8'h4d, 8'h4c, 8'h4b, 8'h4a, 8'h49, 8'h48, 8'h48,
		8'h47, 8'h46, 8'h45, 8'h44, 8'h43, 8'h43, 8'h42, 8'h41,
		8'h40, 8'h3f, 8'h3f, 8'h3e, 8'h3d, 8'h3c, 8'h3c, 8'h3b,
		8'h3a, 8'h39, 8'h39, 8'h38, 8'h37, 8'h36, 8'h36, 8'h35,
		8'h34, 8'h33, 8'h33, 8'h32, 8'h31, 8'h31, 8'h30, 8'h2f,
		8'h2e, 8'h2e, 8'h2d, 8'h2c, 8'h2c, 8'h2b, 8'h2a, 8'h2a,
		8'h29, 8'h28, 8'h28, 8'h27, 8'h26, 8'h26, 8'h25, 8'h24,
		8'h24, 8'h23, 8'h22, 8'h22, 8'h21, 8'h20, 8'h20, 8'h1f,
		8'h1e, 8'h1e, 8'h1d, 8'h1d, 8'h1c, 8'h1b, 8'h1b, 8'h1a,
		8'h19, 8'h19, 8'h18, 8'h18, 8'h17, 8'h16, 8'h16, 8'h15,
		8'h15, 8'h14, 8'h14, 8'h13, 8'h12, 8'h12, 8'h11, 8'h11,
		8'h10, 8'h0f, 8'h0f, 8'h0e, 8'h0e, 8'h0d, 8'h0d, 8'h0c,
		8'h0c, 8'h0b, 8'h0a, 8'h0a, 8'h09, 8'h09, 8'h08, 8'h08,
		8'h07, 8'h07, 8'h06, 8'h06, 8'h05, 8'h05, 8'h04, 8'h04,
		8'h03, 8'h03, 8'h02, 8'h02, 8'h01, 8'h01, 8'h00, 8'h00,
		8'h00
	};

	typedef struct packed {
		logic [16:0] quotient;
		logic        div_overflow;
	} quotient_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;

	quotient_word_t pending_quotients[$];
	logic [15:0]    distance;
	int             src_idle_pct;
	int             sink_idle_pct;
	int             mismatches;
	int             words_checked;
	int             overflow_words;
	int             clamped_words;
	int             distance_writes;

	table_newton_reciprocal_divider_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Bit-exact divide: normalize, seed lookup, two refinements, rounded multiply.
	function automatic quotient_word_t reciprocal_quotient(input logic [15:0] dividend,
			input logic [15:0] depth);
		quotient_word_t res;
		bit [63:0]      num;
		bit [63:0]      den;
		bit [63:0]      recip;
		bit [63:0]      q;
		bit [8:0]       idx;
		int             shift;
		res.quotient     = QUOTIENT_CLAMP;
		res.div_overflow = 1'b1;
		if ((64'(depth) << 1) <= 64'(dividend))
			return res;
		shift = 0;
		while (shift < 15 && !depth[15 - shift])
			shift++;
		num   = 64'(dividend) << shift;
		den   = (64'(depth) << shift) & 64'hffff;
		idx   = 9'(((den & 64'h7fff) + 64'h40) >> 7);
		recip = 64'(RECIP_SEED[idx]) + 64'h101;
		den   = (64'h2000080 - den * recip) >> 8;
		den   = (64'h0000080 + den * recip) >> 8;
		q     = (64'h0008000 + den * num) >> 16;
		if (q > 64'(QUOTIENT_CLAMP))
			q = 64'(QUOTIENT_CLAMP);
		res.quotient     = q[16:0];
		res.div_overflow = 1'b0;
		return res;
	endfunction

	// Called right after a rising edge; leaves s_tvalid high after the handshake.
	task automatic send_depth(input logic [15:0] depth);
		bit taken;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= depth;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			if (taken)
				pending_quotients.push_back(reciprocal_quotient(distance, depth));
			@(posedge clk);
		end
	endtask

	// Holds the sender off until every expected word has been taken.
	task automatic wait_empty();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_quotients.size() != 0);
	endtask

	task automatic write_distance(input logic [15:0] value);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		distance = value;
		distance_writes++;
		@(posedge clk);
	endtask

	function automatic logic [15:0] random_value();
		int width;
		width = $urandom_range(16, 1);
		return 16'($urandom & ((32'h1 << width) - 1));
	endfunction

	// Mostly values of random magnitude, with zero and the overflow edge mixed in.
	function automatic logic [15:0] pick_depth(input logic [15:0] dividend);
		int roll;
		int near;
		roll = $urandom_range(99);
		if (roll < 5)
			return 16'h0000;
		if (roll < 25) begin
			near = int'(dividend >> 1) + $urandom_range(2) - 1;
			if (near < 0)
				near = 0;
			return 16'(near);
		end
		return random_value();
	endfunction

	task automatic log_mismatch(input string what, input logic [23:0] want_data,
			input logic want_flag);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: expected quotient %05h flag %0b, got tdata %06h tuser %0b",
				$time, what, want_data, want_flag, m_tdata, m_tuser);
	endtask

	// Output words are sampled on the falling edge; the handshake completes at
	// the next rising edge, since m_tready only changes on rising edges.
	always @(negedge clk) begin
		quotient_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_quotients.size() == 0) begin
				log_mismatch("word with nothing expected", 24'h0, 1'b0);
			end else begin
				want = pending_quotients.pop_front();
				words_checked++;
				if (want.div_overflow)
					overflow_words++;
				else if (want.quotient == QUOTIENT_CLAMP)
					clamped_words++;
				if (m_tdata !== {7'b0, want.quotient} || m_tuser !== want.div_overflow)
					log_mismatch("wrong word", {7'b0, want.quotient}, want.div_overflow);
			end
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= sink_idle_pct);

	// The register comes out of reset at zero, so every nonzero depth gives zero.
	task automatic test_reset_distance();
		send_depth(16'h0000);
		send_depth(16'h0001);
		send_depth(16'hffff);
		send_depth(16'h1234);
		wait_empty();
	endtask

	task automatic test_extremes();
		write_distance(DIST_MAX);
		send_depth(16'h0000);
		send_depth(16'h0001);
		send_depth(16'h7fff);
		send_depth(16'h8000);
		send_depth(16'h8001);
		send_depth(16'hffff);
		wait_empty();
	endtask

	// Depth just below, at, just above and just beyond half the distance.
	task automatic test_half_boundary();
		write_distance(16'h1235);
		send_depth(16'h091a);
		send_depth(16'h091b);
		send_depth(16'h091c);
		wait_empty();
		write_distance(16'h8000);
		send_depth(16'h4000);
		send_depth(16'h4001);
		wait_empty();
	endtask

	// One depth for each odd normalization shift, all above the overflow edge.
	task automatic test_normalize_shifts();
		write_distance(16'h0001);
		for (int k = 0; k < 16; k += 2)
			send_depth(16'((32'h1 << k) | ($urandom & ((32'h1 << k) - 1))));
		wait_empty();
	endtask

	task automatic test_random_mix(input int count, input int src_pct, input int sink_pct);
		int segment;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		segment = 0;
		for (int i = 0; i < count; i++) begin
			if (i % WORDS_PER_CFG == 0) begin
				wait_empty();
				if (segment % 6 == 0)
					write_distance(DIST_MAX);
				else if (segment % 6 == 3)
					write_distance(16'h0000);
				else
					write_distance(random_value());
				segment++;
			end
			send_depth(pick_depth(distance));
		end
		wait_empty();
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = 16'h0000;
		s_tvalid        = 1'b0;
		s_tdata         = 16'h0000;
		m_tready        = 1'b0;
		distance        = 16'h0000;
		src_idle_pct    = 0;
		sink_idle_pct   = 0;
		mismatches      = 0;
		words_checked   = 0;
		overflow_words  = 0;
		clamped_words   = 0;
		distance_writes = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_distance();
		test_extremes();
		test_half_boundary();
		test_normalize_shifts();
		test_random_mix(430, 31, 65);
		test_random_mix(430, 65, 31);
		test_random_mix(440, 0, 0);

		repeat (12) @(posedge clk);
		$display("Checked %0d quotients: %0d divide overflows, %0d clamped at the top.",
			words_checked, overflow_words, clamped_words);
		$display("Dividend written %0d times, with sender and receiver stalls in turn.",
			distance_writes);
		if (mismatches == 0 && pending_quotients.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d words never arrived", mismatches,
				pending_quotients.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d words outstanding", pending_quotients.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: sim.f
design/tnrd_pkg.sv
design/table_newton_reciprocal_divider_top.sv
tb/tb.sv
